### sv/ced_pkg.sv
// shared types, sizes and helpers for the case-insensitive edit distance core
`timescale 1ns / 1ps
package ced_pkg;

  localparam int MAX_LEN = 64;
  localparam int LEN_W   = $clog2(MAX_LEN + 1);
  localparam int ROW_W   = $clog2(MAX_LEN + 2);
  localparam int IDX_W   = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
  localparam int CNT_W   = $clog2(MAX_LEN + 1);
  localparam int DIST_W  = 7;
  localparam int CHAR_W  = 8;

  typedef enum logic [1:0] {
    ST_LOAD_A,
    ST_LOAD_B,
    ST_DRAIN
  } state_e;

  // per-cell load and init controls
  typedef struct packed {
    logic              load;
    logic              init;
    logic [CHAR_W-1:0] ch;
  } cell_ctl_t;

  // data handed from one cell to the next
  typedef struct packed {
    logic              valid;
    logic [CHAR_W-1:0] ch;
    logic [ROW_W-1:0]  left;
    logic [ROW_W-1:0]  diag;
  } wave_t;

  function automatic logic [CHAR_W-1:0] fold_byte(input logic [CHAR_W-1:0] c);
    logic [CHAR_W-1:0] r;
    r = c;
    if (c >= 8'd65 && c <= 8'd90) begin
      r = c + 8'd32;
    end
    return r;
  endfunction

  function automatic logic [DIST_W-1:0] sat_dist(input logic [ROW_W-1:0] v);
    logic [31:0] w;
    w = 32'(v);
    if (w > 32'd127) begin
      return 7'd127;
    end
    return w[DIST_W-1:0];
  endfunction

endpackage

### sv/case_insensitive_edit_distance_core.sv
// Levenshtein distance (case-insensitive) over a row of MAX_LEN systolic cells.
// Throughput: one item per cycle while strings load; busy_o stays low then.
// Drain: after the last second-string item, busy_o stays high while the last
// update wave runs down the cell row, then done_o pulses one cycle.
// Reset: asynchronous, active low; returns to loading the first string.
// Results cannot be stalled: done_o marks distance_o/truncated_o for one cycle.
`timescale 1ns / 1ps
module case_insensitive_edit_distance_core import ced_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  output logic              busy_o,
  input  logic              string_select_i,
  input  logic [CHAR_W-1:0] character_i,
  input  logic              has_character_i,
  input  logic              last_of_string_i,
  output logic              done_o,
  output logic [DIST_W-1:0] distance_o,
  output logic              truncated_o
);

  state_e            state_q, state_d;
  logic [LEN_W-1:0]  first_len_q, first_len_d;
  logic [LEN_W-1:0]  second_cnt_q, second_cnt_d;
  logic              ovf_q, ovf_d;
  logic [CNT_W-1:0]  drain_q, drain_d;
  logic              done_q, done_d;
  logic [DIST_W-1:0] dist_q;
  logic              trunc_q;

  logic              accept;
  logic              in_phase;
  logic              take_char;
  logic              init_row;
  logic              inject;
  logic              capture;
  logic [CHAR_W-1:0] folded;
  logic [LEN_W-1:0]  sel_idx;
  logic [ROW_W-1:0]  row_sel;

  wave_t             inj_q;
  wave_t             waves [MAX_LEN+1];
  cell_ctl_t         ctls  [MAX_LEN];
  logic [ROW_W-1:0]  row_vals [MAX_LEN];

  assign busy_o = (state_q == ST_DRAIN);
  assign accept = start_i && !busy_o;
  assign folded = fold_byte(character_i);

  always_comb begin
    state_d      = state_q;
    first_len_d  = first_len_q;
    second_cnt_d = second_cnt_q;
    ovf_d        = ovf_q;
    drain_d      = drain_q;
    done_d       = 1'b0;
    take_char    = 1'b0;
    init_row     = 1'b0;
    inject       = 1'b0;
    capture      = 1'b0;
    in_phase     = accept && (string_select_i == (state_q == ST_LOAD_B));
    case (state_q)
      ST_LOAD_A: begin
        if (in_phase) begin
          if (has_character_i) begin
            if (first_len_q < LEN_W'(MAX_LEN)) begin
              take_char   = 1'b1;
              first_len_d = first_len_q + LEN_W'(1);
            end else begin
              ovf_d = 1'b1;
            end
          end
          if (last_of_string_i) begin
            init_row     = 1'b1;
            second_cnt_d = '0;
            state_d      = ST_LOAD_B;
          end
        end
      end
      ST_LOAD_B: begin
        if (in_phase) begin
          if (has_character_i) begin
            if (second_cnt_q < LEN_W'(MAX_LEN)) begin
              inject       = 1'b1;
              second_cnt_d = second_cnt_q + LEN_W'(1);
            end else begin
              ovf_d = 1'b1;
            end
          end
          if (last_of_string_i) begin
            drain_d = CNT_W'(MAX_LEN);
            state_d = ST_DRAIN;
          end
        end
      end
      ST_DRAIN: begin
        if (drain_q != '0) begin
          drain_d = drain_q - CNT_W'(1);
        end else begin
          // wave has passed the last cell, row is final
          capture      = 1'b1;
          done_d       = 1'b1;
          first_len_d  = '0;
          second_cnt_d = '0;
          ovf_d        = 1'b0;
          state_d      = ST_LOAD_A;
        end
      end
      default: begin
        state_d = ST_LOAD_A;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_LOAD_A;
      first_len_q  <= '0;
      second_cnt_q <= '0;
      ovf_q        <= 1'b0;
      drain_q      <= '0;
      done_q       <= 1'b0;
      inj_q        <= '0;
    end else begin
      state_q      <= state_d;
      first_len_q  <= first_len_d;
      second_cnt_q <= second_cnt_d;
      ovf_q        <= ovf_d;
      drain_q      <= drain_d;
      done_q       <= done_d;
      inj_q.valid  <= inject;
      inj_q.ch     <= folded;
      // column zero of the row is the second-string count itself
      inj_q.left   <= ROW_W'(second_cnt_q) + ROW_W'(1);
      inj_q.diag   <= ROW_W'(second_cnt_q);
    end
  end

  always_ff @(posedge clk_i) begin
    if (capture) begin
      dist_q  <= sat_dist(row_sel);
      trunc_q <= ovf_q;
    end
  end

  assign waves[0] = inj_q;

  for (genvar k = 0; k < MAX_LEN; k++) begin : g_cell
    assign ctls[k].load = take_char && (first_len_q == LEN_W'(k));
    assign ctls[k].init = init_row;
    assign ctls[k].ch   = folded;
    assign row_vals[k]  = waves[k+1].left;

    ced_cell u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .ctl_i  (ctls[k]),
      .idx_i  (ROW_W'(k + 1)),
      .wave_i (waves[k]),
      .wave_o (waves[k+1])
    );
  end

  assign sel_idx = first_len_q - LEN_W'(1);
  assign row_sel = (first_len_q == '0) ? ROW_W'(second_cnt_q) : row_vals[sel_idx[IDX_W-1:0]];

  assign done_o      = done_q;
  assign distance_o  = dist_q;
  assign truncated_o = trunc_q;

endmodule

### sv/ced_cell.sv
// one cell of the systolic row: a stored first-string byte and its row entry
`timescale 1ns / 1ps
module ced_cell import ced_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  cell_ctl_t        ctl_i,
  input  logic [ROW_W-1:0] idx_i,
  input  wave_t            wave_i,
  output wave_t            wave_o
);

  logic [CHAR_W-1:0] ch_q;
  logic [ROW_W-1:0]  val_q;
  logic              pv_q;
  logic [CHAR_W-1:0] pb_q;
  logic [ROW_W-1:0]  pdiag_q;

  logic              cost;
  logic [ROW_W-1:0]  up1;
  logic [ROW_W-1:0]  left1;
  logic [ROW_W-1:0]  sub;
  logic [ROW_W-1:0]  val_d;

  always_comb begin
    cost  = (ch_q != wave_i.ch);
    up1   = val_q + ROW_W'(1);
    left1 = wave_i.left + ROW_W'(1);
    sub   = wave_i.diag + ROW_W'(cost);
    val_d = up1;
    if (left1 < val_d) begin
      val_d = left1;
    end
    if (sub < val_d) begin
      val_d = sub;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pv_q <= 1'b0;
    end else begin
      pv_q <= wave_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.load) begin
      ch_q <= ctl_i.ch;
    end
    if (ctl_i.init) begin
      val_q <= idx_i;
    end else if (wave_i.valid) begin
      val_q <= val_d;
    end
    pb_q    <= wave_i.ch;
    // old entry becomes the diagonal of the next cell
    pdiag_q <= val_q;
  end

  assign wave_o.valid = pv_q;
  assign wave_o.ch    = pb_q;
  assign wave_o.left  = val_q;
  assign wave_o.diag  = pdiag_q;

endmodule

### sv/ced_checker.sv
// port-level checks for the edit distance core, bound to the top level
`timescale 1ns / 1ps
module ced_checker import ced_pkg::*; (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              start_i,
  input logic              busy_o,
  input logic              done_o,
  input logic [DIST_W-1:0] distance_o
);

  // a result only follows a drain
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(busy_o) && !busy_o)
    else $error("result without preceding drain");

  // done_o drops again after each result strobe
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !done_o)
    else $error("result strobe longer than one cycle");

  // distance never exceeds MAX_LEN, the longest string that can be stored
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> (32'(distance_o) <= MAX_LEN))
    else $error("distance out of range");

  // busy only rises after a transfer
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(busy_o) |-> $past(start_i))
    else $error("busy without start");

endmodule

bind case_insensitive_edit_distance_core ced_checker u_ced_checker (.*);

### sim/ced_checker.sv
// edit distance checker: predicts each distance result and compares it on done_o
`timescale 1ns / 1ps
module ced_scoreboard import ced_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  logic              busy_o,
  input  logic              string_select_i,
  input  logic [CHAR_W-1:0] character_i,
  input  logic              has_character_i,
  input  logic              last_of_string_i,
  input  logic              done_o,
  input  logic [DIST_W-1:0] distance_o,
  input  logic              truncated_o,
  output int                mismatch_count_o,
  output int                pending_count_o
);

  typedef struct packed {
    logic [DIST_W-1:0] distance;
    logic              trunc;
  } dist_result_t;

  // shadow of the core's string store and dp row
  logic [CHAR_W-1:0] first_bytes [MAX_LEN];
  int                first_len;
  int                second_len;
  int                cost_row [MAX_LEN+1];
  bit                trunc_seen;
  bit                on_second;
  dist_result_t      expected_dist_q [$];

  function automatic logic [CHAR_W-1:0] to_lower(input logic [CHAR_W-1:0] c);
    logic [CHAR_W-1:0] r;
    r = c;
    if (c >= 8'h41 && c <= 8'h5A) begin
      r = c + 8'h20;
    end
    return r;
  endfunction

  // one row step of the dp for a byte of the second string
  function void advance_cost_row(input logic [CHAR_W-1:0] b);
    int diag;
    int up;
    int v;
    int j;
    logic [CHAR_W-1:0] fb;
    fb = to_lower(b);
    diag = cost_row[0];
    cost_row[0] = second_len + 1;
    for (j = 1; j <= first_len; j++) begin
      up = cost_row[j];
      v = up + 1;
      if (cost_row[j-1] + 1 < v) v = cost_row[j-1] + 1;
      if (diag + ((to_lower(first_bytes[j-1]) == fb) ? 0 : 1) < v) begin
        v = diag + ((to_lower(first_bytes[j-1]) == fb) ? 0 : 1);
      end
      diag = up;
      cost_row[j] = v;
    end
  endfunction

  function void absorb_transfer(input logic sel, input logic [CHAR_W-1:0] ch,
                                input logic has, input logic last);
    dist_result_t want;
    int j;
    int d;
    // items of the other string are dropped entirely
    if (sel != on_second) return;
    if (!on_second) begin
      if (has) begin
        if (first_len < MAX_LEN) begin
          first_bytes[first_len] = ch;
          first_len++;
        end else begin
          trunc_seen = 1'b1;
        end
      end
      if (last) begin
        for (j = 0; j <= first_len; j++) cost_row[j] = j;
        second_len = 0;
        on_second = 1'b1;
      end
    end else begin
      if (has) begin
        if (second_len < MAX_LEN) begin
          advance_cost_row(ch);
          second_len++;
        end else begin
          trunc_seen = 1'b1;
        end
      end
      if (last) begin
        d = cost_row[first_len];
        if (d > 127) d = 127;
        want.distance = d[DIST_W-1:0];
        want.trunc = trunc_seen;
        expected_dist_q = {expected_dist_q, want};
        first_len = 0;
        second_len = 0;
        trunc_seen = 1'b0;
        on_second = 1'b0;
      end
    end
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin : watch
    dist_result_t want;
    if (!rst_ni) begin
      first_len = 0;
      second_len = 0;
      trunc_seen = 1'b0;
      on_second = 1'b0;
      for (int j = 0; j <= MAX_LEN; j++) cost_row[j] = 0;
      expected_dist_q.delete();
      mismatch_count_o = 0;
    end else begin
      if (done_o) begin
        if (expected_dist_q.size() == 0) begin
          mismatch_count_o++;
          if (mismatch_count_o <= 10) begin
            $display("%0t: unexpected result dist=%0d trunc=%0d", $time,
                     distance_o, truncated_o);
          end
        end else begin
          want = expected_dist_q.pop_front();
          if (distance_o !== want.distance || truncated_o !== want.trunc) begin
            mismatch_count_o++;
            if (mismatch_count_o <= 10) begin
              $display("%0t: result mismatch: expected dist=%0d trunc=%0d, got dist=%0d trunc=%0d",
                       $time, want.distance, want.trunc, distance_o, truncated_o);
            end
          end
        end
      end
      if (start_i && !busy_o) begin
        absorb_transfer(string_select_i, character_i, has_character_i, last_of_string_i);
      end
    end
    pending_count_o = expected_dist_q.size();
  end

endmodule

### sim/tb_top.sv
// top of the edit distance testbench: clock, reset, string stimulus and verdict
`timescale 1ns / 1ps
module tb_top;
  import ced_pkg::*;

  logic              clk_i;
  logic              rst_ni = 1'b0;
  logic              start_i = 1'b0;
  logic              string_select_i = 1'b0;
  logic [CHAR_W-1:0] character_i = '0;
  logic              has_character_i = 1'b0;
  logic              last_of_string_i = 1'b0;
  logic              busy_o;
  logic              done_o;
  logic [DIST_W-1:0] distance_o;
  logic              truncated_o;
  int                mismatch_count;
  int                pending_count;

  int accepted_items = 0;
  bit gaps_on = 1'b0;

  case_insensitive_edit_distance_core u_dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .start_i          (start_i),
    .busy_o           (busy_o),
    .string_select_i  (string_select_i),
    .character_i      (character_i),
    .has_character_i  (has_character_i),
    .last_of_string_i (last_of_string_i),
    .done_o           (done_o),
    .distance_o       (distance_o),
    .truncated_o      (truncated_o)
  );

  ced_scoreboard u_checker (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .start_i          (start_i),
    .busy_o           (busy_o),
    .string_select_i  (string_select_i),
    .character_i      (character_i),
    .has_character_i  (has_character_i),
    .last_of_string_i (last_of_string_i),
    .done_o           (done_o),
    .distance_o       (distance_o),
    .truncated_o      (truncated_o),
    .mismatch_count_o (mismatch_count),
    .pending_count_o  (pending_count)
  );

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  initial begin
    #(20_000_000);
    $display("tb_top: FAIL");
    $finish;
  end

  // start_i stays high after a transfer so the next item can follow back to back
  task automatic send_item(input logic sel, input logic [CHAR_W-1:0] ch,
                           input logic has, input logic last);
    start_i          <= 1'b1;
    string_select_i  <= sel;
    character_i      <= ch;
    has_character_i  <= has;
    last_of_string_i <= last;
    do @(posedge clk_i); while (busy_o);
  endtask

  task automatic idle_burst();
    if (gaps_on && $urandom_range(0, 3) == 0) begin
      start_i <= 1'b0;
      repeat ($urandom_range(1, 14)) @(posedge clk_i);
    end
  endtask

  // small alphabet half of the time so that matches and case folding show up
  function automatic logic [CHAR_W-1:0] pick_char();
    case ($urandom_range(0, 7))
      0: return 8'h61;
      1: return 8'h41;
      2: return 8'h62;
      3: return 8'h42;
      default: return CHAR_W'($urandom_range(0, 255));
    endcase
  endfunction

  function automatic int pick_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 5) return $urandom_range(MAX_LEN + 1, MAX_LEN + 6);
    if (r < 8) return MAX_LEN;
    if (r < 15) return $urandom_range(9, MAX_LEN - 1);
    return $urandom_range(0, 8);
  endfunction

  task automatic send_string(input logic sel, input int len);
    int  k;
    bit  tail_empty;
    if (len == 0) begin
      idle_burst();
      send_item(sel, pick_char(), 1'b0, 1'b1);
      accepted_items++;
      return;
    end
    for (k = 0; k < len; k++) begin
      idle_burst();
      if ($urandom_range(0, 19) == 0) begin
        // item for the other string, dropped by the core
        send_item(!sel, CHAR_W'($urandom_range(0, 255)),
                  1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
        idle_burst();
      end
      if ($urandom_range(0, 29) == 0) begin
        send_item(sel, CHAR_W'($urandom_range(0, 255)), 1'b0, 1'b0);
        accepted_items++;
        idle_burst();
      end
      tail_empty = (k == len - 1) && ($urandom_range(0, 7) == 0);
      send_item(sel, pick_char(), 1'b1, (k == len - 1) && !tail_empty);
      accepted_items++;
      if (tail_empty) begin
        idle_burst();
        send_item(sel, pick_char(), 1'b0, 1'b1);
        accepted_items++;
      end
    end
  endtask

  initial begin
    int wait_cycles;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // both strings empty
    send_item(1'b0, 8'h00, 1'b0, 1'b1);
    send_item(1'b1, 8'hFF, 1'b0, 1'b1);
    // second-string item while loading the first, then upper vs lower case
    send_item(1'b1, 8'hFF, 1'b1, 1'b1);
    send_item(1'b0, 8'h41, 1'b1, 1'b1);
    send_item(1'b1, 8'h61, 1'b1, 1'b1);
    // byte extremes, a stray first-string item and a no-character item mid string
    send_item(1'b0, 8'h00, 1'b1, 1'b0);
    send_item(1'b0, 8'hFF, 1'b1, 1'b1);
    send_item(1'b1, 8'hFF, 1'b1, 1'b0);
    send_item(1'b0, 8'h00, 1'b1, 1'b1);
    send_item(1'b1, 8'h00, 1'b0, 1'b0);
    send_item(1'b1, 8'h00, 1'b1, 1'b1);
    // bytes just outside and at the upper edge of the upper- and lower-case ranges
    send_item(1'b0, 8'h40, 1'b1, 1'b0);
    send_item(1'b0, 8'h5B, 1'b1, 1'b0);
    send_item(1'b0, 8'h5A, 1'b1, 1'b1);
    send_item(1'b1, 8'h60, 1'b1, 1'b0);
    send_item(1'b1, 8'h7B, 1'b1, 1'b0);
    send_item(1'b1, 8'h7A, 1'b1, 1'b1);
    // empty first string, second string closed by an item without a character
    send_item(1'b0, 8'h5A, 1'b0, 1'b1);
    send_item(1'b1, 8'h78, 1'b1, 1'b0);
    send_item(1'b1, 8'h79, 1'b1, 1'b0);
    send_item(1'b1, 8'h00, 1'b0, 1'b1);

    while (accepted_items < 800) begin
      gaps_on = (accepted_items < 640) && ($urandom_range(0, 2) != 0);
      send_string(1'b0, pick_len());
      send_string(1'b1, pick_len());
    end
    start_i <= 1'b0;

    wait_cycles = 0;
    while (pending_count != 0 && wait_cycles < 10000) begin
      @(posedge clk_i);
      wait_cycles++;
    end
    repeat (MAX_LEN + 8) @(posedge clk_i);

    if (mismatch_count == 0 && pending_count == 0) begin
      $display("tb_top: PASS");
    end else begin
      $display("tb_top: FAIL");
    end
    $finish;
  end

endmodule
